### rtl/ptmr_pkg.sv
package ptmr_pkg;

    localparam int GLYPH_WIDTH     = 8;
    localparam int DEF_MAX_DEVICES = 8;
    localparam int DEF_GLYPH_COUNT = 16;
    localparam int DEF_MAX_TEXT    = 16;
    localparam int DIGIT_GLYPH     = 8'h08;
    localparam int FIRST_OWN_GLYPH = 8'h0A;

    localparam logic [1:0] CFG_DEVICE_COUNT = 2'd0;
    localparam logic [1:0] CFG_SCAN_LINES   = 2'd1;
    localparam logic [1:0] CFG_ALIGNMENT    = 2'd2;

    localparam logic [1:0] ALIGN_CENTER = 2'd1;
    localparam logic [1:0] ALIGN_LEFT   = 2'd2;

    localparam logic OP_LOAD_ROW = 1'b0;
    localparam logic OP_ADD_CHAR = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [3:0] glyph_index;
        logic [2:0] row_index;
        logic [7:0] row_bits;
        logic [7:0] char_code;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [3:0] line_register;
        logic [7:0] column_byte;
        logic       frame_end;
        logic       display_end;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GL_RD,
        S_GL_WR,
        S_LAY_INIT,
        S_LAY_TXT,
        S_LAY_GLY,
        S_LAY_CALC,
        S_ALIGN,
        S_CLR,
        S_DR_TXT,
        S_DR_GLY,
        S_DR_COL,
        S_DR_WR,
        S_EM_RD,
        S_EM_OUT
    } state_t;

    typedef struct packed {
        logic in_take;
        logic gl_rd;
        logic gl_wr;
        logic lay_init;
        logic lay_txt_rd;
        logic lay_gly_rd;
        logic lay_step;
        logic align;
        logic clr_step;
        logic dr_txt_rd;
        logic dr_next;
        logic dr_gly_rd;
        logic dr_col_rd;
        logic dr_col_skip;
        logic dr_col_wr;
        logic em_init;
        logic em_rd;
        logic em_out;
        logic done;
    } cmd_t;

    typedef struct packed {
        logic in_op;
        logic in_eot;
        logic gl_ok;
        logic len_zero;
        logic d_one;
        logic clr_done;
        logic d_at_len;
        logic code_skip;
        logic col_done;
        logic at_in;
        logic out_free;
        logic last_m;
        logic last_i;
    } status_t;

endpackage

### rtl/proportional_text_matrix_render.sv
// proportional text renderer for a chain of 8x8 matrix drivers
// input channel (in_valid/in_stall/in_data): glyph row loads and text characters,
//   a beat is taken when in_valid is high and in_stall is low
// a glyph row load with an index inside the glyph store is accepted, then reads the glyph word and writes it back
// a text character is accepted on its own; the one marked end_of_text starts a render
// render: a setup step, per character a text read, glyph read and layout step,
//   an alignment step, a clearing pass of the frame store, then per character a
//   text read, a glyph step, a read and write per drawn column and a skip per column
//   dropped past the end, a step to close the walk, then a read and an output per word
// the render emits device_count * scan_lines beats on the output channel,
//   per scan line one word per device, last device first
// in_stall stays high for the whole render; the sequencer and its single-port
//   frame store set this order of steps
// output channel (out_valid/out_stall/out_data) is a registered stage; a stalled
//   beat holds and the sequencer waits for it before it loads the next word
// config port (cfg_write/cfg_index/cfg_data) writes a register
// reset: glyph store reads as zero, text is empty, registers go to 4 devices,
//   8 scan lines and right alignment
module proportional_text_matrix_render
    import ptmr_pkg::*;
#(
    parameter int MAX_DEVICES = DEF_MAX_DEVICES,
    parameter int GLYPH_COUNT = DEF_GLYPH_COUNT,
    parameter int MAX_TEXT    = DEF_MAX_TEXT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    // sequencer
    ptmr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // stores, counters and output stage
    ptmr_datapath #(
        .MAX_DEVICES (MAX_DEVICES),
        .GLYPH_COUNT (GLYPH_COUNT),
        .MAX_TEXT    (MAX_TEXT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // a last character always starts a render
    a_render_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.operation == OP_ADD_CHAR && in_data.end_of_text
        |=> in_stall)
        else $error("render did not start after last character");

    // a display end word is always a frame end word
    a_display_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.display_end |-> out_data.frame_end)
        else $error("display end without frame end");

    // scan line register is never zero
    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.line_register != 4'd0)
        else $error("line register zero");

    // output words only come while a render holds the input side
    a_out_in_render: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("output word outside render");

endmodule

### rtl/ptmr_ctrl.sv
module ptmr_ctrl
    import ptmr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_take = 1'b1;
                    if (status.in_op == OP_LOAD_ROW)
                    begin
                        if (status.gl_ok)
                        begin
                            state_next = S_GL_RD;
                        end
                    end
                    else if (status.in_eot)
                    begin
                        state_next = S_LAY_INIT;
                    end
                end
            end
            S_GL_RD:
            begin
                cmd.gl_rd  = 1'b1;
                state_next = S_GL_WR;
            end
            S_GL_WR:
            begin
                cmd.gl_wr  = 1'b1;
                state_next = S_IDLE;
            end
            S_LAY_INIT:
            begin
                cmd.lay_init = 1'b1;
                state_next   = status.len_zero ? S_ALIGN : S_LAY_TXT;
            end
            S_LAY_TXT:
            begin
                cmd.lay_txt_rd = 1'b1;
                state_next     = S_LAY_GLY;
            end
            S_LAY_GLY:
            begin
                cmd.lay_gly_rd = 1'b1;
                state_next     = S_LAY_CALC;
            end
            S_LAY_CALC:
            begin
                cmd.lay_step = 1'b1;
                state_next   = status.d_one ? S_ALIGN : S_LAY_TXT;
            end
            S_ALIGN:
            begin
                cmd.align  = 1'b1;
                state_next = S_CLR;
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_done)
                begin
                    state_next = S_DR_TXT;
                end
            end
            S_DR_TXT:
            begin
                if (status.d_at_len)
                begin
                    cmd.em_init = 1'b1;
                    state_next  = S_EM_RD;
                end
                else
                begin
                    cmd.dr_txt_rd = 1'b1;
                    state_next    = S_DR_GLY;
                end
            end
            S_DR_GLY:
            begin
                if (status.code_skip)
                begin
                    cmd.dr_next = 1'b1;
                    state_next  = S_DR_TXT;
                end
                else
                begin
                    cmd.dr_gly_rd = 1'b1;
                    state_next    = S_DR_COL;
                end
            end
            S_DR_COL:
            begin
                priority if (status.col_done)
                begin
                    cmd.dr_next = 1'b1;
                    state_next  = S_DR_TXT;
                end
                else if (status.at_in)
                begin
                    cmd.dr_col_rd = 1'b1;
                    state_next    = S_DR_WR;
                end
                else
                begin
                    cmd.dr_col_skip = 1'b1;
                end
            end
            S_DR_WR:
            begin
                cmd.dr_col_wr = 1'b1;
                state_next    = S_DR_COL;
            end
            S_EM_RD:
            begin
                cmd.em_rd  = 1'b1;
                state_next = S_EM_OUT;
            end
            S_EM_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.em_out = 1'b1;
                    if (status.last_m && status.last_i)
                    begin
                        cmd.done   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/ptmr_datapath.sv
module ptmr_datapath
    import ptmr_pkg::*;
#(
    parameter int MAX_DEVICES = DEF_MAX_DEVICES,
    parameter int GLYPH_COUNT = DEF_GLYPH_COUNT,
    parameter int MAX_TEXT    = DEF_MAX_TEXT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  logic      cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data,
    input  cmd_t      cmd,
    output status_t   status,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int GIDX_W     = $clog2(GLYPH_COUNT);
    localparam int TIDX_W     = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
    localparam int LEN_W      = $clog2(MAX_TEXT + 1);
    localparam int FRAME_SIZE = MAX_DEVICES * 8;
    localparam int FIDX_W     = $clog2(FRAME_SIZE);
    localparam int DEV_W      = $clog2(MAX_DEVICES + 1);
    localparam int GWORD_W    = GLYPH_WIDTH * 8;
    localparam int LAY_W      = 15;

    // configuration
    logic [3:0] dev_cfg_reg;
    logic [3:0] scan_cfg_reg;
    logic [1:0] align_reg;

    logic [DEV_W-1:0] dev_eff;
    logic [3:0]       scan_eff;
    logic [6:0]       total;

    // glyph store
    logic [GWORD_W-1:0]     glyph_mem [GLYPH_COUNT];
    logic [GLYPH_COUNT-1:0] glyph_valid_reg;
    logic [GWORD_W-1:0]     glyph_rd_reg;
    logic [GWORD_W-1:0]     glyph_new;
    logic [GIDX_W-1:0]      glyph_addr;
    logic                   glyph_rd_en;
    logic [GIDX_W-1:0]      ld_glyph_reg;
    logic [2:0]             ld_row_reg;
    logic [7:0]             ld_bits_reg;

    // text and layout stores
    logic [7:0]       text_mem [MAX_TEXT];
    logic [7:0]       text_rd_reg;
    logic [LAY_W-1:0] lay_mem [MAX_TEXT];
    logic [LAY_W-1:0] lay_rd_reg;
    logic [TIDX_W-1:0] text_addr;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] d_reg;
    logic [LEN_W-1:0] d_dec;
    logic [7:0]       mapped;

    // limits
    logic [7:0] lit;
    logic [2:0] lim_first;
    logic [2:0] lim_last;
    logic [3:0] lim_width;

    logic [7:0] pos_reg;
    logic [7:0] off_reg;
    logic [7:0] span;

    // frame store
    logic [7:0]        frame_mem [FRAME_SIZE];
    logic [7:0]        frame_rd_reg;
    logic [FIDX_W-1:0] frame_rd_addr;
    logic [FIDX_W-1:0] clr_cnt_reg;

    // draw
    logic [7:0] lay_place;
    logic [2:0] lay_first;
    logic [3:0] lay_width;
    logic [3:0] l_reg;
    logic [7:0] base;
    logic [8:0] at;
    logic [2:0] col;
    logic [7:0] col_byte;

    // emit
    logic [2:0]       i_reg;
    logic [DEV_W-1:0] m_reg;
    logic [6:0]       em_addr;
    logic             out_valid_reg;
    out_item_t        out_data_reg;
    logic             out_free;

    assign dev_eff  = (dev_cfg_reg == 4'd0 || dev_cfg_reg > MAX_DEVICES)
                      ? DEV_W'(MAX_DEVICES) : dev_cfg_reg[DEV_W-1:0];
    assign scan_eff = (scan_cfg_reg[2:0] == 3'd0) ? 4'd8 : {1'b0, scan_cfg_reg[2:0]};
    assign total    = 7'(dev_eff) * 7'(scan_eff);

    // row j bit k lands in column 7-k bit 7-j
    always_comb
    begin
        glyph_new = glyph_rd_reg;
        for (int c = 0; c < 8; c++)
        begin
            glyph_new[c * 8 + 7 - int'(ld_row_reg)] = ld_bits_reg[7 - c];
        end
    end

    always_comb
    begin
        lim_first = 3'd0;
        lim_last  = 3'd0;
        for (int c = 0; c < 8; c++)
        begin
            lit[c] = |glyph_rd_reg[c * 8 +: 8];
        end
        for (int c = 7; c >= 0; c--)
        begin
            if (lit[c])
            begin
                lim_first = 3'(c);
            end
        end
        for (int c = 0; c < 8; c++)
        begin
            if (lit[c])
            begin
                lim_last = 3'(c);
            end
        end
        lim_width = (|lit) ? ({1'b0, lim_last} - {1'b0, lim_first} + 4'd1) : 4'd0;
    end

    // codes outside the own-glyph range share the digit limits
    assign mapped = ({1'b0, text_rd_reg} >= GLYPH_COUNT || text_rd_reg < FIRST_OWN_GLYPH)
                    ? 8'(DIGIT_GLYPH) : text_rd_reg;

    always_comb
    begin
        priority if (cmd.gl_rd)
        begin
            glyph_addr = ld_glyph_reg;
        end
        else if (cmd.lay_gly_rd)
        begin
            glyph_addr = mapped[GIDX_W-1:0];
        end
        else
        begin
            glyph_addr = text_rd_reg[GIDX_W-1:0];
        end
    end
    assign glyph_rd_en = cmd.gl_rd | cmd.lay_gly_rd | cmd.dr_gly_rd;

    assign d_dec     = d_reg - LEN_W'(1);
    assign text_addr = cmd.lay_txt_rd ? d_dec[TIDX_W-1:0] : d_reg[TIDX_W-1:0];

    assign span = 8'(total) - pos_reg + 8'd1;

    assign lay_place = lay_rd_reg[14:7];
    assign lay_first = lay_rd_reg[6:4];
    assign lay_width = lay_rd_reg[3:0];
    assign base      = lay_place + off_reg;
    assign at        = {1'b0, base} + 9'(l_reg);
    assign col       = lay_first + l_reg[2:0];
    assign col_byte  = glyph_rd_reg[{col, 3'b000} +: 8];

    assign em_addr       = 7'(m_reg - DEV_W'(1)) * 7'(scan_eff) + 7'(i_reg);
    assign frame_rd_addr = cmd.dr_col_rd ? at[FIDX_W-1:0] : em_addr[FIDX_W-1:0];

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        status.in_op     = in_data.operation;
        status.in_eot    = in_data.end_of_text;
        status.gl_ok     = in_data.glyph_index < GLYPH_COUNT;
        status.len_zero  = (len_reg == '0);
        status.d_one     = (d_reg == LEN_W'(1));
        status.clr_done  = (clr_cnt_reg == FIDX_W'(FRAME_SIZE - 1));
        status.d_at_len  = (d_reg == len_reg);
        status.code_skip = ({1'b0, text_rd_reg} >= GLYPH_COUNT) || (lay_width == 4'd0);
        status.col_done  = (l_reg == lay_width);
        status.at_in     = (at < 9'(total));
        status.out_free  = out_free;
        status.last_m    = (m_reg == DEV_W'(1));
        status.last_i    = ({1'b0, i_reg} == scan_eff - 4'd1);
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.gl_wr)
        begin
            glyph_mem[ld_glyph_reg] <= glyph_new;
        end
        if (glyph_rd_en)
        begin
            glyph_rd_reg <= glyph_valid_reg[glyph_addr] ? glyph_mem[glyph_addr] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_take && in_data.operation == OP_ADD_CHAR && len_reg < MAX_TEXT)
        begin
            text_mem[len_reg[TIDX_W-1:0]] <= in_data.char_code;
        end
        if (cmd.lay_txt_rd || cmd.dr_txt_rd)
        begin
            text_rd_reg <= text_mem[text_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lay_step)
        begin
            lay_mem[d_dec[TIDX_W-1:0]] <= {pos_reg, lim_first, lim_width};
        end
        if (cmd.dr_txt_rd)
        begin
            lay_rd_reg <= lay_mem[d_reg[TIDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            frame_mem[clr_cnt_reg] <= 8'd0;
        end
        else if (cmd.dr_col_wr)
        begin
            frame_mem[at[FIDX_W-1:0]] <= frame_rd_reg | col_byte;
        end
        if (cmd.dr_col_rd || cmd.em_rd)
        begin
            frame_rd_reg <= frame_mem[frame_rd_addr];
        end
    end

    // load latches and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.in_take)
        begin
            ld_glyph_reg <= GIDX_W'(in_data.glyph_index);
            ld_row_reg   <= in_data.row_index;
            ld_bits_reg  <= in_data.row_bits;
        end
        if (cmd.em_out)
        begin
            out_data_reg.line_register <= {1'b0, i_reg} + 4'd1;
            out_data_reg.column_byte   <= frame_rd_reg;
            out_data_reg.frame_end     <= status.last_m;
            out_data_reg.display_end   <= status.last_m && status.last_i;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_cfg_reg     <= 4'd4;
            scan_cfg_reg    <= 4'd8;
            align_reg       <= 2'd0;
            glyph_valid_reg <= '0;
            len_reg         <= '0;
            d_reg           <= '0;
            pos_reg         <= 8'd0;
            off_reg         <= 8'd0;
            clr_cnt_reg     <= '0;
            l_reg           <= 4'd0;
            i_reg           <= 3'd0;
            m_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_DEVICE_COUNT: dev_cfg_reg  <= cfg_data;
                    CFG_SCAN_LINES:   scan_cfg_reg <= cfg_data;
                    CFG_ALIGNMENT:    align_reg    <= cfg_data[1:0];
                    default:          ;
                endcase
            end
            if (cmd.gl_wr)
            begin
                glyph_valid_reg[ld_glyph_reg] <= 1'b1;
            end
            if (cmd.in_take && in_data.operation == OP_ADD_CHAR && len_reg < MAX_TEXT)
            begin
                len_reg <= len_reg + LEN_W'(1);
            end
            if (cmd.lay_init)
            begin
                d_reg   <= len_reg;
                pos_reg <= 8'd0;
            end
            if (cmd.lay_step)
            begin
                pos_reg <= pos_reg + 8'(lim_width) + 8'd1;
                d_reg   <= d_dec;
            end
            if (cmd.align)
            begin
                d_reg       <= '0;
                clr_cnt_reg <= '0;
                if (pos_reg < 8'(total) && align_reg == ALIGN_CENTER)
                begin
                    off_reg <= {1'b0, span[7:1]};
                end
                else if (pos_reg < 8'(total) && align_reg == ALIGN_LEFT)
                begin
                    off_reg <= span;
                end
                else
                begin
                    off_reg <= 8'd0;
                end
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + FIDX_W'(1);
            end
            if (cmd.dr_next)
            begin
                d_reg <= d_reg + LEN_W'(1);
            end
            if (cmd.dr_gly_rd)
            begin
                l_reg <= 4'd0;
            end
            if (cmd.dr_col_skip || cmd.dr_col_wr)
            begin
                l_reg <= l_reg + 4'd1;
            end
            if (cmd.em_init)
            begin
                i_reg <= 3'd0;
                m_reg <= dev_eff;
            end
            if (cmd.em_out)
            begin
                if (status.last_m)
                begin
                    m_reg <= dev_eff;
                    i_reg <= i_reg + 3'd1;
                end
                else
                begin
                    m_reg <= m_reg - DEV_W'(1);
                end
            end
            if (cmd.done)
            begin
                len_reg <= '0;
            end
            if (cmd.em_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
